[design/toy_core_instruction_step_core_macros.svh]
// ----------------------------------------------------------------------------
// toy_core_instruction_step_core_macros.svh
// assertion helpers for the instruction step core
// ----------------------------------------------------------------------------
`ifndef TOY_CORE_INSTRUCTION_STEP_CORE_MACROS_SVH
`define TOY_CORE_INSTRUCTION_STEP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcis_pkg.sv]
// ----------------------------------------------------------------------------
// tcis_pkg
// types and constants shared by the instruction step core
// ----------------------------------------------------------------------------
`default_nettype none

package tcis_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WIDTH = 64;
    localparam int IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PC_W       = 29;
    localparam int DIST_W     = 27;

    // opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_OR  = 4'd1;
    localparam logic [3:0] OP_XOR = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd3;
    localparam logic [3:0] OP_ADC = 4'd4;
    localparam logic [3:0] OP_CMP = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_SBC = 4'd7;
    localparam logic [3:0] OP_MOV = 4'd8;
    localparam logic [3:0] OP_LSH = 4'd9;
    localparam logic [3:0] OP_RSH = 4'd10;

    // branch conditions
    localparam logic [3:0] COND_NONE = 4'd0;
    localparam logic [3:0] COND_EQ   = 4'd2;
    localparam logic [3:0] COND_NE   = 4'd3;
    localparam logic [3:0] COND_LE   = 4'd4;
    localparam logic [3:0] COND_GE   = 4'd5;
    localparam logic [3:0] COND_LT   = 4'd6;
    localparam logic [3:0] COND_GT   = 4'd7;

    // compare flag bit positions
    localparam int FLAG_EQ = 0;
    localparam int FLAG_NE = 1;
    localparam int FLAG_LE = 2;
    localparam int FLAG_GE = 3;
    localparam int FLAG_LT = 4;
    localparam int FLAG_GT = 5;

    // run status codes
    localparam logic [1:0] STAT_RUNNING  = 2'd0;
    localparam logic [1:0] STAT_FINISHED = 2'd1;
    localparam logic [1:0] STAT_NEGATIVE = 2'd2;

    typedef struct packed {
        logic [3:0]        branch_cond;
        logic              branch_back;
        logic [DIST_W-1:0] branch_distance;
        logic              imm_select;
        logic [3:0]        opcode;
        logic [3:0]        src_a;
        logic [3:0]        src_b;
        logic [3:0]        dest_reg;
        logic [7:0]        immediate;
    } t_in_item;

    typedef struct packed {
        logic signed [PC_W-1:0] next_pc;
        logic                   write_done;
        logic [3:0]             written_index;
        logic [DATA_WIDTH-1:0]  written_value;
        logic                   carry_out;
        logic [1:0]             run_status;
    } t_out_item;

endpackage

`default_nettype wire

[design/toy_core_instruction_step_core.sv]
// ----------------------------------------------------------------------------
// toy_core_instruction_step_core
// executes one decoded instruction per transaction on a small register machine
// ----------------------------------------------------------------------------
// Usage:
//   input channel i_in_valid / o_in_ready carries one decoded instruction,
//   output channel o_out_valid / i_out_ready returns one result per instruction.
//   i_cfg_we / i_cfg_data write program_length; the user must do so only while
//   the core is idle, and the core itself does not enforce this.
// Path: an accepted instruction and its register file read are registered in
//   the execute stage, and execute then loads the output register.
// Throughput: one instruction per cycle when stall-free. The register file is a
//   synchronous memory with two read ports; a write at the edge where the next
//   instruction reads is forwarded, so dependent instructions issue back to back.
// Reset: synchronous, active low. Clears pc, carry, compare flags,
//   program_length and the per-entry valid bits (so every register reads 0).
//   With program_length 0 every instruction reports the run as finished.
// Stall: when the receiver holds i_out_ready low the result waits in the
//   output register; one more instruction is read and parked in the execute
//   stage, then o_in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toy_core_instruction_step_core_macros.svh"

module toy_core_instruction_step_core (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_in_valid,
    output logic                                      o_in_ready,
    input  wire  tcis_pkg::t_in_item                  i_in_data,
    output logic                                      o_out_valid,
    input  wire                                       i_out_ready,
    output tcis_pkg::t_out_item                       o_out_data,
    input  wire                                       i_cfg_we,
    input  wire  [tcis_pkg::DIST_W-1:0]               i_cfg_data
);

    localparam int DW   = tcis_pkg::DATA_WIDTH;
    localparam int IW   = tcis_pkg::IDX_W;
    localparam int PW   = tcis_pkg::PC_W;
    localparam int NR   = tcis_pkg::NUM_REGS;

    // register file and its valid bits
    logic [DW-1:0]        mem [NR];
    logic [NR-1:0]        r_reg_vld;

    // execute stage
    logic                 r_s1_valid;
    tcis_pkg::t_in_item   r_s1;
    logic [DW-1:0]        r_rd_a;
    logic [DW-1:0]        r_rd_b;
    logic                 r_a_vld;
    logic                 r_b_vld;
    logic                 r_fwd_vld;
    logic [IW-1:0]        r_fwd_idx;
    logic [DW-1:0]        r_fwd_val;

    // architectural state
    logic [PW-1:0]        r_pc;
    logic                 r_carry;
    logic [5:0]           r_flags;
    logic [tcis_pkg::DIST_W-1:0] r_prog_len;

    // output register
    logic                 r_out_valid;
    tcis_pkg::t_out_item  r_out;

    logic                 w_out_free;
    logic                 w_s1_fire;
    logic                 w_s1_load;
    logic [IW-1:0]        w_rd_a_idx;
    logic [IW-1:0]        w_rd_b_idx;

    logic                 w_a_oob;
    logic                 w_b_oob;
    logic                 w_d_oob;
    logic [DW-1:0]        w_a;
    logic [DW-1:0]        w_b_reg;
    logic [DW-1:0]        w_b;
    logic [DW-1:0]        w_b_eff;
    logic                 w_cin;
    logic [DW:0]          w_sum;
    logic                 w_running;
    logic                 w_cond_ok;
    logic                 w_wr;
    logic [DW-1:0]        w_val;
    logic                 w_we;
    logic [IW-1:0]        w_widx;

    logic [PW-1:0]        n_pc;
    logic                 n_carry;
    logic [5:0]           n_flags;
    logic [1:0]           w_status;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_fire  = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_s1_fire;
    assign w_s1_load  = i_in_valid && o_in_ready;
    assign w_rd_a_idx = i_in_data.src_a[IW-1:0];
    assign w_rd_b_idx = i_in_data.src_b[IW-1:0];

    // ------------------------------------------------------------------
    // register file: one write port, two registered read ports
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_widx] <= w_val;
        end
        if (w_s1_load) begin
            r_rd_a  <= mem[w_rd_a_idx];
            r_rd_b  <= mem[w_rd_b_idx];
            r_a_vld <= r_reg_vld[w_rd_a_idx];
            r_b_vld <= r_reg_vld[w_rd_b_idx];
            r_s1    <= i_in_data;
            // remember the write landing at the same edge as this read
            r_fwd_idx <= w_widx;
            r_fwd_val <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            if (w_we) begin
                r_reg_vld[w_widx] <= 1'b1;
            end
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
                r_fwd_vld  <= w_we;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // execute
    // ------------------------------------------------------------------
    assign w_a_oob = ({1'b0, r_s1.src_a} >= 5'(NR));
    assign w_b_oob = ({1'b0, r_s1.src_b} >= 5'(NR));
    assign w_d_oob = ({1'b0, r_s1.dest_reg} >= 5'(NR));
    assign w_widx  = r_s1.dest_reg[IW-1:0];

    always_comb begin
        if (w_a_oob) begin
            w_a = '0;
        end else if (r_fwd_vld && r_fwd_idx == r_s1.src_a[IW-1:0]) begin
            w_a = r_fwd_val;
        end else begin
            w_a = r_a_vld ? r_rd_a : '0;
        end
        if (w_b_oob) begin
            w_b_reg = '0;
        end else if (r_fwd_vld && r_fwd_idx == r_s1.src_b[IW-1:0]) begin
            w_b_reg = r_fwd_val;
        end else begin
            w_b_reg = r_b_vld ? r_rd_b : '0;
        end
    end

    assign w_b = r_s1.imm_select ? DW'(r_s1.immediate) : w_b_reg;

    // one adder serves add, adc, sub, sbc and compare
    always_comb begin
        w_b_eff = w_b;
        w_cin   = 1'b0;
        case (r_s1.opcode)
            tcis_pkg::OP_ADC: begin
                w_cin = r_carry;
            end
            tcis_pkg::OP_SUB, tcis_pkg::OP_CMP: begin
                w_b_eff = ~w_b;
                w_cin   = 1'b1;
            end
            tcis_pkg::OP_SBC: begin
                w_b_eff = ~w_b;
                w_cin   = r_carry;
            end
            default: begin
                w_b_eff = w_b;
                w_cin   = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, w_a} + {1'b0, w_b_eff} + (DW+1)'(w_cin);

    assign w_running = !r_pc[PW-1] && (r_pc[PW-2:0] < (PW-1)'(r_prog_len));

    always_comb begin
        case (r_s1.branch_cond)
            tcis_pkg::COND_EQ: w_cond_ok = r_flags[tcis_pkg::FLAG_EQ];
            tcis_pkg::COND_NE: w_cond_ok = r_flags[tcis_pkg::FLAG_NE];
            tcis_pkg::COND_LE: w_cond_ok = r_flags[tcis_pkg::FLAG_LE];
            tcis_pkg::COND_GE: w_cond_ok = r_flags[tcis_pkg::FLAG_GE];
            tcis_pkg::COND_LT: w_cond_ok = r_flags[tcis_pkg::FLAG_LT];
            tcis_pkg::COND_GT: w_cond_ok = r_flags[tcis_pkg::FLAG_GT];
            default:           w_cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_pc    = r_pc;
        n_carry = r_carry;
        n_flags = r_flags;
        w_wr    = 1'b0;
        w_val   = '0;
        if (w_running) begin
            n_pc = r_pc + PW'(1);
            if (r_s1.branch_cond != tcis_pkg::COND_NONE) begin
                if (w_cond_ok) begin
                    n_pc = r_s1.branch_back ? (r_pc - PW'(r_s1.branch_distance))
                                            : (r_pc + PW'(r_s1.branch_distance));
                end
            end else begin
                w_wr = 1'b1;
                case (r_s1.opcode)
                    tcis_pkg::OP_AND: w_val = w_a & w_b;
                    tcis_pkg::OP_OR:  w_val = w_a | w_b;
                    tcis_pkg::OP_XOR: w_val = w_a ^ w_b;
                    tcis_pkg::OP_ADD, tcis_pkg::OP_ADC: begin
                        w_val   = w_sum[DW-1:0];
                        n_carry = w_sum[DW];
                    end
                    tcis_pkg::OP_CMP: begin
                        // carry out of a + ~b + 1 means a >= b
                        w_wr = 1'b0;
                        n_flags[tcis_pkg::FLAG_EQ] = (w_a == w_b);
                        n_flags[tcis_pkg::FLAG_NE] = (w_a != w_b);
                        n_flags[tcis_pkg::FLAG_GE] = w_sum[DW];
                        n_flags[tcis_pkg::FLAG_LT] = !w_sum[DW];
                        n_flags[tcis_pkg::FLAG_LE] = !w_sum[DW] || (w_a == w_b);
                        n_flags[tcis_pkg::FLAG_GT] = w_sum[DW] && (w_a != w_b);
                    end
                    tcis_pkg::OP_SUB, tcis_pkg::OP_SBC: w_val = w_sum[DW-1:0];
                    tcis_pkg::OP_MOV: w_val = w_b;
                    tcis_pkg::OP_LSH: w_val = (w_b >= DW'(DW)) ? '0 : (w_a << w_b);
                    tcis_pkg::OP_RSH: w_val = (w_b >= DW'(DW)) ? '0 : (w_a >> w_b);
                    default: w_wr = 1'b0;
                endcase
                if (w_d_oob) begin
                    w_wr = 1'b0;
                end
            end
        end
    end

    assign w_we = w_s1_fire && w_wr;

    always_comb begin
        if (n_pc[PW-1]) begin
            w_status = tcis_pkg::STAT_NEGATIVE;
        end else if (n_pc[PW-2:0] >= (PW-1)'(r_prog_len)) begin
            w_status = tcis_pkg::STAT_FINISHED;
        end else begin
            w_status = tcis_pkg::STAT_RUNNING;
        end
    end

    // ------------------------------------------------------------------
    // architectural state, configuration and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_carry     <= 1'b0;
            r_flags     <= '0;
            r_prog_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_data;
            end
            if (w_s1_fire) begin
                r_pc        <= n_pc;
                r_carry     <= n_carry;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out.next_pc       <= n_pc;
            r_out.write_done    <= w_wr;
            r_out.written_index <= w_wr ? r_s1.dest_reg : 4'd0;
            r_out.written_value <= w_wr ? w_val : '0;
            r_out.carry_out     <= n_carry;
            r_out.run_status    <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `TCIS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_s1_fire, r_out_valid,
        "executed instruction did not reach the output register")
    `TCIS_ASSERT_NOW(a_no_write_clean, i_clk, i_rst_n,
        r_out_valid && !r_out.write_done,
        r_out.written_index == 4'd0 && r_out.written_value == '0,
        "result without a register write carries index or value")
    `TCIS_ASSERT_NOW(a_fwd_entry_valid, i_clk, i_rst_n, r_fwd_vld,
        r_reg_vld[r_fwd_idx], "forwarded register entry never marked valid")
    `TCIS_ASSERT_NOW(a_status_code, i_clk, i_rst_n, r_out_valid,
        r_out.run_status == tcis_pkg::STAT_RUNNING ||
        r_out.run_status == tcis_pkg::STAT_FINISHED ||
        r_out.run_status == tcis_pkg::STAT_NEGATIVE,
        "run status holds an unused code")

endmodule

`default_nettype wire
